/* rtl/core/bpq_pkg.sv */
// Shared types and constants for the beacon period qualifier.
package bpq_pkg;

    localparam int unsigned TimeWidth    = 16;
    localparam int unsigned ExtWidth     = 32;
    localparam int unsigned RunWidth     = 8;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 32;

    localparam logic [ExtWidth-1:0] LowerBoundReset  = 32'd3425;
    localparam logic [ExtWidth-1:0] UpperBoundReset  = 32'd3470;
    localparam logic [RunWidth-1:0] RequiredRunReset = 8'd2;
    localparam logic [RunWidth-1:0] RunMax           = 8'd255;

    typedef enum logic [1:0] {
        OP_CAPTURE  = 2'd0,
        OP_ROLLOVER = 2'd1,
        OP_ARM      = 2'd2
    } op_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_LOWER_BOUND  = 2'd0,
        CFG_UPPER_BOUND  = 2'd1,
        CFG_REQUIRED_RUN = 2'd2
    } cfg_idx_t;

endpackage

/* rtl/core/beacon_period_qualifier.sv */
// Beacon period qualifier: extends capture timestamps and tests edge periods.
//
// Input channel (s_valid/s_ready) takes one item per handshake: a capture
// timestamp, a timer rollover tick or an arm command. Every accepted item
// yields exactly one result item on the m_valid/m_ready channel carrying the
// latest period, whether a pending rollover was consumed, the run count,
// the found flag and the armed state after the item.
//
// The item is registered on acceptance and its result is registered when it
// advances into the result register, which waits while a result is stalled.
// Throughput is one item per cycle unless the receiver stalls: the extend,
// subtract, window compare and run update sit in one stage between the registers.
//
// When the receiver stalls, the result register holds, the input register
// fills behind it and s_ready drops; nothing is lost or repeated.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
// and are meant to be issued only while no item is in flight.
// Reset (aresetn low, synchronous) empties both registers, clears the
// rollover count, previous time, period, run and armed state, and restores
// the window bounds and required run to their defaults.
module beacon_period_qualifier
    import bpq_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_wdata,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_op,
    input  logic [TimeWidth-1:0]    s_capture_time,
    input  logic                    s_rollover_pending,
    input  logic                    s_last_in_burst,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ExtWidth-1:0]     m_period,
    output logic                    m_rollover_taken,
    output logic [RunWidth-1:0]     m_run_count,
    output logic                    m_found,
    output logic                    m_armed_now
);

    // configuration
    logic [ExtWidth-1:0]  lower_bound_reg;
    logic [ExtWidth-1:0]  upper_bound_reg;
    logic [RunWidth-1:0]  required_run_reg;

    // block state
    logic [TimeWidth-1:0] rollover_count_reg, rollover_count_next;
    logic [ExtWidth-1:0]  previous_time_reg, previous_time_next;
    logic [ExtWidth-1:0]  last_period_reg, last_period_next;
    logic [RunWidth-1:0]  valid_run_reg, valid_run_next;
    logic                 armed_reg, armed_next;

    // input register
    logic                 in_valid_reg;
    logic [1:0]           in_op_reg;
    logic [TimeWidth-1:0] in_time_reg;
    logic                 in_pend_reg;
    logic                 in_last_reg;

    // result register
    logic                 out_valid_reg;
    logic [ExtWidth-1:0]  out_period_reg;
    logic                 out_taken_reg;
    logic [RunWidth-1:0]  out_run_reg;
    logic                 out_found_reg;
    logic                 out_armed_reg;

    logic                 advance;
    logic                 taken;
    logic                 found;
    logic [TimeWidth-1:0] roll_used;
    logic [ExtWidth-1:0]  ext_time;
    logic [ExtWidth-1:0]  period_calc;
    logic                 in_window;
    logic [RunWidth-1:0]  run_tested;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_bound_reg  <= LowerBoundReset;
            upper_bound_reg  <= UpperBoundReset;
            required_run_reg <= RequiredRunReset;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LOWER_BOUND:  lower_bound_reg  <= cfg_wdata;
                CFG_UPPER_BOUND:  upper_bound_reg  <= cfg_wdata;
                CFG_REQUIRED_RUN: required_run_reg <= cfg_wdata[RunWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        rollover_count_next = rollover_count_reg;
        previous_time_next  = previous_time_reg;
        last_period_next    = last_period_reg;
        valid_run_next      = valid_run_reg;
        armed_next          = armed_reg;
        taken               = 1'b0;
        found               = 1'b0;
        roll_used           = rollover_count_reg;
        run_tested          = valid_run_reg;

        // consume a pending rollover only for timestamps in the low half
        if (in_pend_reg && !in_time_reg[TimeWidth-1]) begin
            roll_used = TimeWidth'(rollover_count_reg + 1'b1);
        end
        ext_time    = {roll_used, in_time_reg};
        period_calc = ext_time - previous_time_reg;
        in_window   = (lower_bound_reg < period_calc) && (period_calc < upper_bound_reg);

        unique case (in_op_reg)
            OP_ROLLOVER: begin
                rollover_count_next = TimeWidth'(rollover_count_reg + 1'b1);
            end
            OP_ARM: begin
                armed_next = 1'b1;
            end
            OP_CAPTURE: begin
                taken               = in_pend_reg && !in_time_reg[TimeWidth-1];
                rollover_count_next = roll_used;
                previous_time_next  = ext_time;
                last_period_next    = period_calc;
                if (in_last_reg && armed_reg) begin
                    if (!in_window) begin
                        run_tested = '0;
                    end else if (valid_run_reg != RunMax) begin
                        run_tested = RunWidth'(valid_run_reg + 1'b1);
                    end
                    valid_run_next = run_tested;
                    if (run_tested >= required_run_reg) begin
                        valid_run_next = '0;
                        armed_next     = 1'b0;
                        found          = 1'b1;
                    end
                end
            end
            default: ;  // unused code: no state change
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rollover_count_reg <= '0;
            previous_time_reg  <= '0;
            last_period_reg    <= '0;
            valid_run_reg      <= '0;
            armed_reg          <= 1'b0;
        end else if (advance) begin
            rollover_count_reg <= rollover_count_next;
            previous_time_reg  <= previous_time_next;
            last_period_reg    <= last_period_next;
            valid_run_reg      <= valid_run_next;
            armed_reg          <= armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_time_reg <= s_capture_time;
            in_pend_reg <= s_rollover_pending;
            in_last_reg <= s_last_in_burst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_period_reg <= last_period_next;
            out_taken_reg  <= taken;
            out_run_reg    <= valid_run_next;
            out_found_reg  <= found;
            out_armed_reg  <= armed_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_period         = out_period_reg;
    assign m_rollover_taken = out_taken_reg;
    assign m_run_count      = out_run_reg;
    assign m_found          = out_found_reg;
    assign m_armed_now      = out_armed_reg;

endmodule

/* rtl/core/bpq_checker.sv */
// Port-level checks for the beacon period qualifier, bound to the top level.
module bpq_checker
    import bpq_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ExtWidth-1:0] m_period,
    input logic                m_rollover_taken,
    input logic [RunWidth-1:0] m_run_count,
    input logic                m_found,
    input logic                m_armed_now
);

    // a stalled result item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_period) && $stable(m_run_count)
            && $stable(m_found) && $stable(m_armed_now) && $stable(m_rollover_taken))
        else $error("stalled result item changed");

    // found clears the run and disarms on the same item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_armed_now && (m_run_count == '0))
        else $error("found without run clear and disarm");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a nonzero run exists only while armed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_run_count != '0) |-> m_armed_now)
        else $error("run count nonzero while disarmed");

endmodule

bind beacon_period_qualifier bpq_checker u_bpq_checker (.*);

/* bench/beacon_period_qualifier_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the beacon period qualifier: directed table, then random traffic.
module beacon_period_qualifier_test
    import bpq_pkg::*;
();

    localparam logic [1:0]  OpUnused   = 2'd3;
    localparam logic [15:0] HalfScale  = 16'h8000;
    localparam int unsigned CycleLimit = 1_000_000;
    localparam int unsigned NumPlan    = 22;
    localparam int unsigned PhaseItems = 52;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] stamp;
        logic        pend;
        logic        last;
    } beacon_event_t;

    typedef struct packed {
        logic [31:0] period;
        logic        taken;
        logic [7:0]  run;
        logic        found;
        logic        armed;
    } beacon_verdict_t;

    typedef struct {
        beacon_event_t   ev;
        bit              typed;
        beacon_verdict_t want;
    } plan_row_t;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [7:0]  need;
    } window_t;

    logic                    aclk;
    logic                    aresetn            = 1'b0;
    logic                    cfg_we             = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_index          = '0;
    logic [CfgDataWidth-1:0] cfg_wdata          = '0;
    logic                    s_valid            = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_op               = '0;
    logic [TimeWidth-1:0]    s_capture_time     = '0;
    logic                    s_rollover_pending = 1'b0;
    logic                    s_last_in_burst    = 1'b0;
    logic                    m_valid;
    logic                    m_ready            = 1'b0;
    logic [ExtWidth-1:0]     m_period;
    logic                    m_rollover_taken;
    logic [RunWidth-1:0]     m_run_count;
    logic                    m_found;
    logic                    m_armed_now;

    // predictor state and its copy of the registers
    logic [15:0] rollovers;
    logic [31:0] prev_stamp;
    logic [31:0] held_period;
    logic [7:0]  run_len;
    logic        armed_q;
    logic [31:0] win_lo;
    logic [31:0] win_hi;
    logic [7:0]  run_needed;

    beacon_verdict_t pending_results[$];
    plan_row_t       plan [NumPlan];
    int unsigned     mismatches = 0;
    int unsigned     cycle_cnt  = 0;
    bit              calm       = 1'b0;

    beacon_period_qualifier dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_capture_time     (s_capture_time),
        .s_rollover_pending (s_rollover_pending),
        .s_last_in_burst    (s_last_in_burst),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_period           (m_period),
        .m_rollover_taken   (m_rollover_taken),
        .m_run_count        (m_run_count),
        .m_found            (m_found),
        .m_armed_now        (m_armed_now)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt == CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 11);
    end

    task automatic log_mismatch(input string msg);
        if (mismatches < 40)
            $display("[%0t] %s", $time, msg);
        mismatches++;
    endtask

    function automatic beacon_verdict_t qualify_edge(input beacon_event_t ev);
        beacon_verdict_t r;
        logic [31:0]     now;
        r = '0;
        case (ev.op)
            OP_ROLLOVER: rollovers = rollovers + 16'd1;
            OP_ARM:      armed_q = 1'b1;
            OP_CAPTURE: begin
                if (ev.pend && ev.stamp < HalfScale) begin
                    rollovers = rollovers + 16'd1;
                    r.taken = 1'b1;
                end
                now = {rollovers, ev.stamp};
                held_period = now - prev_stamp;
                prev_stamp = now;
                if (ev.last && armed_q) begin
                    if (win_lo < held_period && held_period < win_hi) begin
                        if (run_len < RunMax)
                            run_len = run_len + 8'd1;
                    end else begin
                        run_len = '0;
                    end
                    if (run_len >= run_needed) begin
                        run_len = '0;
                        armed_q = 1'b0;
                        r.found = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.period = held_period;
        r.run    = run_len;
        r.armed  = armed_q;
        return r;
    endfunction

    task automatic send_event(input beacon_event_t ev, input bit typed,
                              input beacon_verdict_t want);
        beacon_verdict_t pred;
        if (!calm && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_op               <= ev.op;
        s_capture_time     <= ev.stamp;
        s_rollover_pending <= ev.pend;
        s_last_in_burst    <= ev.last;
        do @(posedge aclk); while (!s_ready);
        pred = qualify_edge(ev);
        pending_results.push_back(typed ? want : pred);
    endtask

    // drop valid and hold until every result is back
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic set_window(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [7:0] need);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOWER_BOUND;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_UPPER_BOUND;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_REQUIRED_RUN;
        cfg_wdata <= {24'd0, need};
        @(posedge aclk);
        cfg_we     <= 1'b0;
        win_lo     = lo;
        win_hi     = hi;
        run_needed = need;
    endtask

    // outputs are stable from the falling edge until the edge that moves them
    always @(negedge aclk) begin : check_results
        beacon_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                log_mismatch("result item with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (m_period != want.period)
                    log_mismatch($sformatf("period %h, expected %h", m_period, want.period));
                if (m_rollover_taken != want.taken)
                    log_mismatch($sformatf("rollover_taken %b, expected %b",
                                           m_rollover_taken, want.taken));
                if (m_run_count != want.run)
                    log_mismatch($sformatf("run_count %0d, expected %0d",
                                           m_run_count, want.run));
                if (m_found != want.found)
                    log_mismatch($sformatf("found %b, expected %b", m_found, want.found));
                if (m_armed_now != want.armed)
                    log_mismatch($sformatf("armed_now %b, expected %b",
                                           m_armed_now, want.armed));
            end
        end
    end

    initial begin
        window_t       windows [8];
        beacon_event_t ev;
        logic [31:0]   aim;
        logic [31:0]   target;
        logic [15:0]   hop;
        logic          lean;
        int unsigned   pick;

        rollovers   = '0;
        prev_stamp  = '0;
        held_period = '0;
        run_len     = '0;
        armed_q     = 1'b0;
        win_lo      = LowerBoundReset;
        win_hi      = UpperBoundReset;
        run_needed  = RequiredRunReset;

        // window 3425..3470 exclusive, two runs to qualify
        plan = '{
            '{'{OP_ROLLOVER, 16'd0,     1'b0, 1'b0}, 1'b1, '{32'd0,          1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{OP_CAPTURE,  16'hFFFF,  1'b1, 1'b1}, 1'b1, '{32'h0001_FFFF,  1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{OP_CAPTURE,  16'h0000,  1'b1, 1'b0}, 1'b1, '{32'd1,          1'b1, 8'd0, 1'b0, 1'b0}},
            '{'{OP_ARM,      16'd0,     1'b0, 1'b0}, 1'b1, '{32'd1,          1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_ARM,      16'hFFFF,  1'b1, 1'b1}, 1'b1, '{32'd1,          1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd3450,  1'b0, 1'b1}, 1'b1, '{32'd3450,       1'b0, 8'd1, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd6900,  1'b0, 1'b0}, 1'b1, '{32'd3450,       1'b0, 8'd1, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd10350, 1'b0, 1'b1}, 1'b1, '{32'd3450,       1'b0, 8'd0, 1'b1, 1'b0}},
            '{'{OP_CAPTURE,  16'd13775, 1'b0, 1'b1}, 1'b1, '{32'd3425,       1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{OP_ARM,      16'd0,     1'b0, 1'b0}, 1'b1, '{32'd3425,       1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd17200, 1'b0, 1'b1}, 1'b1, '{32'd3425,       1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd20670, 1'b0, 1'b1}, 1'b1, '{32'd3470,       1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd24139, 1'b0, 1'b1}, 1'b1, '{32'd3469,       1'b0, 8'd1, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'd27565, 1'b0, 1'b1}, 1'b1, '{32'd3426,       1'b0, 8'd0, 1'b1, 1'b0}},
            '{'{OpUnused,    16'hFFFF,  1'b1, 1'b1}, 1'b1, '{32'd3426,       1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{OP_CAPTURE,  16'h7FFF,  1'b1, 1'b1}, 1'b0, '0},
            '{'{OP_CAPTURE,  16'h8000,  1'b1, 1'b0}, 1'b1, '{32'd1,          1'b0, 8'd0, 1'b0, 1'b0}},
            '{'{OP_ARM,      16'd0,     1'b0, 1'b0}, 1'b1, '{32'd1,          1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_CAPTURE,  16'h0000,  1'b0, 1'b1}, 1'b1, '{32'hFFFF_8000,  1'b0, 8'd0, 1'b0, 1'b1}},
            '{'{OP_ROLLOVER, 16'h5A5A,  1'b1, 1'b0}, 1'b0, '0},
            '{'{OP_ROLLOVER, 16'hA5A5,  1'b0, 1'b1}, 1'b0, '0},
            '{'{OP_CAPTURE,  16'h1234,  1'b1, 1'b1}, 1'b0, '0}
        };

        windows[0] = '{LowerBoundReset, UpperBoundReset, RequiredRunReset};
        windows[1] = '{32'd0, 32'hFFFF_FFFF, 8'd1};
        windows[2] = '{32'd3000, 32'd3100, 8'd255};
        windows[3] = '{32'd1000, 32'd1200, 8'd0};
        windows[4] = '{32'hFFFF_FFFF, 32'd0, 8'd3};
        windows[5] = '{32'd500, 32'd502, 8'd1};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NumPlan; i++)
            send_event(plan[i].ev, plan[i].typed, plan[i].want);
        settle();

        // run a stretch of rollover ticks back to back on both sides
        calm = 1'b1;
        repeat (40) begin
            ev    = 20'($urandom);
            ev.op = OP_ROLLOVER;
            send_event(ev, 1'b0, '0);
        end
        send_event('{OP_CAPTURE, 16'h0001, 1'b1, 1'b1}, 1'b0, '0);
        settle();
        calm = 1'b0;

        for (int ph = 0; ph < 8; ph++) begin
            if (ph >= 6) begin
                windows[ph].lo   = $urandom_range(0, 200000);
                windows[ph].hi   = windows[ph].lo + $urandom_range(0, 3000);
                windows[ph].need = $urandom_range(1, 8);
            end
            set_window(windows[ph].lo, windows[ph].hi, windows[ph].need);
            for (int n = 0; n < PhaseItems; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    ev = 20'($urandom);
                    send_event(ev, 1'b0, '0);
                end else if (pick < 18 || (!armed_q && pick < 45)) begin
                    ev    = 20'($urandom);
                    ev.op = OP_ARM;
                    send_event(ev, 1'b0, '0);
                end else begin
                    if (win_hi > win_lo + 32'd1 && win_hi - win_lo < 32'd100000
                            && win_lo < 32'd400000) begin
                        case ($urandom_range(0, 9))
                            0:       aim = win_lo;
                            1:       aim = win_hi;
                            2:       aim = $urandom_range(1, 150000);
                            default: aim = win_lo + 32'd1
                                           + $urandom_range(0, win_hi - win_lo - 32'd2);
                        endcase
                    end else begin
                        aim = $urandom_range(1, 150000);
                    end
                    target = prev_stamp + aim;
                    hop    = target[31:16] - rollovers;
                    // stray ticks ran the count past the target: take the period as it comes
                    if (hop > 16'd40)
                        hop = '0;
                    lean = (hop != 0) && (target[15:0] < HalfScale)
                           && ($urandom_range(0, 1) == 1);
                    repeat (hop - lean) begin
                        ev    = 20'($urandom);
                        ev.op = OP_ROLLOVER;
                        send_event(ev, 1'b0, '0);
                    end
                    ev.op    = OP_CAPTURE;
                    ev.stamp = target[15:0];
                    ev.pend  = lean || (target[15:0] >= HalfScale && $urandom_range(0, 1) == 1);
                    ev.last  = $urandom_range(0, 3) != 0;
                    send_event(ev, 1'b0, '0);
                end
            end
            settle();
        end

        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
